@@ rtl/kbbc_pkg.sv @@
// Package for the keyword block balance checker.
// Holds the word types, scanner modes, status codes and character helpers.
// No dependencies.
package kbbc_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] err_line;
    logic [15:0] err_column;
    logic        finished;
  } out_word_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BEGIN   = 3'd1,
    MODE_END     = 3'd2,
    MODE_REPEAT  = 3'd3,
    MODE_UNTIL   = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_STRING  = 3'd6
  } mode_e;

  localparam logic [2:0] ST_CONTINUE    = 3'd0;
  localparam logic [2:0] ST_CORRECT     = 3'd1;
  localparam logic [2:0] ST_END_ORPHAN  = 3'd2;
  localparam logic [2:0] ST_UNTIL_ORPHAN = 3'd3;
  localparam logic [2:0] ST_BEGIN_OPEN  = 3'd4;
  localparam logic [2:0] ST_REPEAT_OPEN = 3'd5;
  localparam logic [2:0] ST_OVERFLOW    = 3'd6;

  localparam logic KIND_BEGIN  = 1'b0;
  localparam logic KIND_REPEAT = 1'b1;

  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_I       = 8'h49;
  localparam logic [7:0] CH_L       = 8'h4C;
  localparam logic [7:0] CH_N       = 8'h4E;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_U       = 8'h55;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  localparam logic [15:0] END_BACK   = 16'd3;
  localparam logic [15:0] UNTIL_BACK = 16'd5;

  function automatic logic [7:0] fold_case(input logic [7:0] ch);
    if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
      return ch - 8'h20;
    end
    return ch;
  endfunction

  function automatic logic opens_word(input logic [7:0] ch);
    return ch == CH_SPACE || ch == CH_SEMI || ch == CH_RBRACE ||
           ch == CH_NEWLINE || ch == CH_QUOTE;
  endfunction

  function automatic logic closes_word(input logic [7:0] ch);
    return ch == CH_SPACE || ch == CH_SEMI || ch == CH_LBRACE ||
           ch == CH_NEWLINE || ch == CH_QUOTE;
  endfunction

  function automatic logic [15:0] col_back(input logic [15:0] col,
                                           input logic [15:0] n);
    return (col > n) ? (col - n) : 16'd0;
  endfunction

endpackage

@@ rtl/keyword_block_balance_checker.sv @@
// Top level of the keyword block balance checker.
// Scanner, kind stack and two-entry result buffer; uses kbbc_pkg.

// The checker takes one text byte per word and gives one registered status word
// for every byte. A byte can be accepted in every cycle while input ready is high:
// the scanner state, the line and column counters and the kind stack are all
// updated in the cycle of acceptance, and the stack is a shift register whose top
// two entries are read directly. Results pass through a two-entry buffer, so
// input ready falls only when two results wait to be taken. After a final status
// the scanner returns to its reset state and the next byte starts a new text.
module keyword_block_balance_checker
  import kbbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  mode_e                  mode_q, mode_d;
  logic [7:0]             prev_q, prev_d;
  logic [15:0]            line_q, line_d;
  logic [15:0]            col_q, col_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d;
  logic [STACK_DEPTH-1:0] stk_q, stk_d;

  out_word_t head_q, head_d, skid_q, skid_d, res;
  logic      head_v_q, head_v_d, skid_v_q, skid_v_d;
  logic      in_fire, out_fire;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = head_v_q;
  assign out_word_o  = head_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = head_v_q && out_ready_i;

  always_comb begin
    logic [7:0]             c, p;
    mode_e                  mode1, mode2;
    logic                   do_push, push_kind, do_pop, pop_want;
    logic [2:0]             err, pop_err, st;
    logic [15:0]            ecol, pop_back, col2, line2, rcol;
    logic [DEPTH_W-1:0]     depth1, depth2;
    logic [STACK_DEPTH-1:0] stk1;
    logic                   top, finish;

    c         = fold_case(in_word_i.text_char);
    p         = prev_q;
    mode1     = mode_q;
    do_push   = 1'b0;
    push_kind = KIND_BEGIN;
    do_pop    = 1'b0;
    pop_want  = KIND_BEGIN;
    pop_err   = ST_END_ORPHAN;
    pop_back  = END_BACK;
    err       = ST_CONTINUE;
    ecol      = 16'd0;

    unique case (mode_q)
      MODE_IDLE: begin
        if (opens_word(p)) begin
          if (c == CH_B) mode1 = MODE_BEGIN;
          else if (c == CH_E) mode1 = MODE_END;
          else if (c == CH_R) mode1 = MODE_REPEAT;
          else if (c == CH_U) mode1 = MODE_UNTIL;
        end
      end
      MODE_BEGIN: begin
        if (!((p == CH_B && c == CH_E) || (p == CH_E && c == CH_G) ||
              (p == CH_G && c == CH_I) || (p == CH_I && c == CH_N))) begin
          mode1 = MODE_IDLE;
        end
        if (p == CH_N && closes_word(c)) begin
          do_push   = 1'b1;
          push_kind = KIND_BEGIN;
        end
      end
      MODE_END: begin
        if (!((p == CH_E && c == CH_N) || (p == CH_N && c == CH_D))) begin
          mode1 = MODE_IDLE;
        end
        if (p == CH_D && (closes_word(c) || c == CH_DOT)) begin
          do_pop   = 1'b1;
          pop_want = KIND_BEGIN;
          pop_err  = ST_END_ORPHAN;
          pop_back = END_BACK;
        end
      end
      MODE_REPEAT: begin
        if (!((p == CH_R && c == CH_E) || (p == CH_E && c == CH_P) ||
              (p == CH_P && c == CH_E) || (p == CH_E && c == CH_A) ||
              (p == CH_A && c == CH_T))) begin
          mode1 = MODE_IDLE;
        end
        if (p == CH_T && closes_word(c)) begin
          do_push   = 1'b1;
          push_kind = KIND_REPEAT;
        end
      end
      MODE_UNTIL: begin
        if (!((p == CH_U && c == CH_N) || (p == CH_N && c == CH_T) ||
              (p == CH_T && c == CH_I) || (p == CH_I && c == CH_L))) begin
          mode1 = MODE_IDLE;
        end
        if (p == CH_L && closes_word(c)) begin
          do_pop   = 1'b1;
          pop_want = KIND_REPEAT;
          pop_err  = ST_UNTIL_ORPHAN;
          pop_back = UNTIL_BACK;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_RBRACE) mode1 = MODE_IDLE;
      end
      default: begin
      end
    endcase

    depth1 = depth_q;
    stk1   = stk_q;
    if (do_push) begin
      if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
        err  = ST_OVERFLOW;
        ecol = col_q;
      end else begin
        depth1 = depth_q + 1'b1;
        stk1   = {stk_q[STACK_DEPTH-2:0], push_kind};
      end
    end
    if (do_pop) begin
      if (depth_q == '0 || stk_q[0] != pop_want) begin
        err  = pop_err;
        ecol = col_back(col_q, pop_back);
      end
      if (depth_q != '0) begin
        depth1 = depth_q - 1'b1;
        stk1   = {1'b0, stk_q[STACK_DEPTH-1:1]};
      end
    end

    mode2 = mode1;
    if (c == CH_QUOTE) begin
      if (mode1 == MODE_STRING) mode2 = MODE_IDLE;
      else if (mode1 != MODE_COMMENT) mode2 = MODE_STRING;
    end
    if (c == CH_LBRACE) mode2 = MODE_COMMENT;

    col2  = (col_q != 16'hFFFF) ? col_q + 16'd1 : col_q;
    line2 = line_q;
    if (c == CH_NEWLINE) begin
      if (line_q != 16'hFFFF) line2 = line_q + 16'd1;
      col2 = 16'd1;
    end

    res    = '0;
    finish = 1'b0;
    depth2 = depth1;
    top    = stk1[0];
    st     = ST_CONTINUE;
    rcol   = col2;
    if (err != ST_CONTINUE) begin
      res    = '{status: err, err_line: line_q, err_column: ecol, finished: 1'b1};
      finish = 1'b1;
    end else if (in_word_i.last_char) begin
      if (mode2 == MODE_END && c == CH_D) begin
        if (depth1 == '0 || stk1[0] != KIND_BEGIN) begin
          st   = ST_END_ORPHAN;
          rcol = col_back(col2, END_BACK);
        end else begin
          depth2 = depth1 - 1'b1;
          top    = stk1[1];
        end
      end
      if (st == ST_CONTINUE) begin
        if (depth2 != '0) begin
          st = (top == KIND_REPEAT) ? ST_REPEAT_OPEN : ST_BEGIN_OPEN;
        end else begin
          st = ST_CORRECT;
        end
      end
      if (st == ST_CORRECT) begin
        res = '{status: st, err_line: 16'd0, err_column: 16'd0, finished: 1'b1};
      end else begin
        res = '{status: st, err_line: line2, err_column: rcol, finished: 1'b1};
      end
      finish = 1'b1;
    end

    mode_d  = mode_q;
    prev_d  = prev_q;
    line_d  = line_q;
    col_d   = col_q;
    depth_d = depth_q;
    stk_d   = stk_q;
    if (in_fire) begin
      stk_d = stk1;
      if (finish) begin
        mode_d  = MODE_IDLE;
        prev_d  = CH_SPACE;
        line_d  = 16'd1;
        col_d   = 16'd0;
        depth_d = '0;
      end else begin
        mode_d  = mode2;
        prev_d  = c;
        line_d  = line2;
        col_d   = col2;
        depth_d = depth1;
      end
    end
  end

  always_comb begin
    head_d   = head_q;
    head_v_d = head_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (out_fire || !head_v_q) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        head_v_d = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        head_d   = res;
        head_v_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d   = res;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      prev_q   <= CH_SPACE;
      line_q   <= 16'd1;
      col_q    <= 16'd0;
      depth_q  <= '0;
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      prev_q   <= prev_d;
      line_q   <= line_d;
      col_q    <= col_d;
      depth_q  <= depth_d;
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stk_q  <= stk_d;
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule
